// ===== rtl/dmc_pkg.sv =====
// Shared constants and types for the direct-mapped cache tag lookup core.
package dmc_pkg;

  localparam int ADDR_W          = 32;
  localparam int CNT_W           = 32;
  localparam int DEF_INDEX_BITS  = 13;
  localparam int DEF_OFFSET_BITS = 3;
  localparam int DEF_TAG_BITS    = 16;

  // Depth of the request queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RESOLVE
  } back_state_t;

  // Status the back end hands to the front end.
  typedef struct packed {
    logic clearing;
    logic take;
  } back_ctl_t;

endpackage

// ===== rtl/dmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/dmc_front.sv =====
// Front end: splits each address into index and tag and queues the request.
module dmc_front #(
  parameter int INDEX_BITS  = dmc_pkg::DEF_INDEX_BITS,
  parameter int OFFSET_BITS = dmc_pkg::DEF_OFFSET_BITS,
  parameter int TAG_BITS    = dmc_pkg::DEF_TAG_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [dmc_pkg::ADDR_W-1:0] address,
  input  dmc_pkg::back_ctl_t        ctl,
  output logic                      q_avail,
  output logic [INDEX_BITS-1:0]     q_index,
  output logic [TAG_BITS-1:0]       q_tag
);
  import dmc_pkg::*;

  logic [2*ADDR_W-1:0] addr_ext;
  logic [INDEX_BITS-1:0] in_index;
  logic [TAG_BITS-1:0]   in_tag;

  logic [INDEX_BITS-1:0] index_q [QDEPTH];
  logic [TAG_BITS-1:0]   tag_q   [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCNT_W-1:0]     count;
  logic                  do_push;
  logic                  do_pop;

  // Tag bits beyond the address read as zero.
  assign addr_ext = {{ADDR_W{1'b0}}, address};
  assign in_index = addr_ext[OFFSET_BITS +: INDEX_BITS];
  assign in_tag   = addr_ext[OFFSET_BITS + INDEX_BITS +: TAG_BITS];

  assign full    = (count == QCNT_W'(QDEPTH)) || ctl.clearing;
  assign do_push = push && !full;
  assign q_avail = (count != '0);
  assign do_pop  = ctl.take && q_avail;
  assign q_index = index_q[rd_ptr];
  assign q_tag   = tag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      index_q[wr_ptr] <= in_index;
      tag_q[wr_ptr]   <= in_tag;
    end
  end

endmodule

// ===== rtl/dmc_back.sv =====
// Back end: tag store lookup and update, hit/miss counters, result register.
module dmc_back #(
  parameter int INDEX_BITS = dmc_pkg::DEF_INDEX_BITS,
  parameter int TAG_BITS   = dmc_pkg::DEF_TAG_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_avail,
  input  logic [INDEX_BITS-1:0]     q_index,
  input  logic [TAG_BITS-1:0]       q_tag,
  output dmc_pkg::back_ctl_t        ctl,
  output logic                      empty,
  input  logic                      pop,
  output logic                      hit,
  output logic [dmc_pkg::CNT_W-1:0] hit_total,
  output logic [dmc_pkg::CNT_W-1:0] miss_total
);
  import dmc_pkg::*;

  localparam int ENTRY_W = TAG_BITS + 1;
  localparam int DEPTH   = 1 << INDEX_BITS;

  back_state_t state, state_next;
  logic [INDEX_BITS-1:0] clr_cnt;
  logic [INDEX_BITS-1:0] cur_index;
  logic [TAG_BITS-1:0]   cur_tag;
  logic                  out_valid;
  logic                  hit_r;
  logic [CNT_W-1:0]      hit_cnt;
  logic [CNT_W-1:0]      miss_cnt;

  logic                  ram_wr_en;
  logic [INDEX_BITS-1:0] ram_wr_addr;
  logic [ENTRY_W-1:0]    ram_wr_data;
  logic                  ram_rd_en;
  logic [ENTRY_W-1:0]    ram_rd_data;
  logic                  is_hit;
  logic                  done;

  // Entry layout: valid bit on top, tag below.
  dmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (q_index),
    .rd_data (ram_rd_data)
  );

  assign is_hit = ram_rd_data[TAG_BITS] && (ram_rd_data[TAG_BITS-1:0] == cur_tag);

  always_comb begin
    state_next   = state;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = cur_index;
    ram_wr_data  = {1'b1, cur_tag};
    ram_rd_en    = 1'b0;
    ctl.take     = 1'b0;
    ctl.clearing = 1'b0;
    done         = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        // sweep the store, one line per cycle
        ctl.clearing = 1'b1;
        ram_wr_en    = 1'b1;
        ram_wr_addr  = clr_cnt;
        ram_wr_data  = '0;
        if (clr_cnt == '1) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_avail) begin
          ram_rd_en  = 1'b1;
          ctl.take   = 1'b1;
          state_next = BK_RESOLVE;
        end
      end
      BK_RESOLVE: begin
        // hold until the result register frees up; read data stays put
        if (!out_valid || pop) begin
          done       = 1'b1;
          ram_wr_en  = !is_hit;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (done) begin
        out_valid <= 1'b1;
        if (is_hit) begin
          if (hit_cnt != '1) hit_cnt <= hit_cnt + 1'b1;
        end else begin
          if (miss_cnt != '1) miss_cnt <= miss_cnt + 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cur_index <= q_index;
      cur_tag   <= q_tag;
    end
    if (done) begin
      hit_r <= is_hit;
    end
  end

  // Counters change only when a new result loads, so they double as the result.
  assign empty      = !out_valid;
  assign hit        = hit_r;
  assign hit_total  = hit_cnt;
  assign miss_total = miss_cnt;

endmodule

// ===== rtl/direct_mapped_cache_hit_miss_core.sv =====
// Top level of the direct-mapped cache tag lookup core.
//
//  channel  | handshake          | beat contents
//  ---------+--------------------+---------------------------------
//  request  | push / full        | address
//  result   | pop / empty        | hit, hit_total, miss_total
//
// Each request passes through BK_IDLE, which issues the tag RAM read, then
// BK_RESOLVE, which does the compare and the write on a miss; the registered
// read of the tag RAM sets these steps. Requests queue in a 2-entry queue.
// After reset, full stays high while the valid bits of all 2**INDEX_BITS lines
// (8192 by default) are swept clear, one line per cycle.
// A result that is not popped holds the back end; the queue keeps taking beats until it fills.
module direct_mapped_cache_hit_miss_core #(
  parameter int INDEX_BITS  = dmc_pkg::DEF_INDEX_BITS,
  parameter int OFFSET_BITS = dmc_pkg::DEF_OFFSET_BITS,
  parameter int TAG_BITS    = dmc_pkg::DEF_TAG_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [dmc_pkg::ADDR_W-1:0] address,
  output logic                       empty,
  input  logic                       pop,
  output logic                       hit,
  output logic [dmc_pkg::CNT_W-1:0]  hit_total,
  output logic [dmc_pkg::CNT_W-1:0]  miss_total
);
  import dmc_pkg::*;

  back_ctl_t             ctl;
  logic                  q_avail;
  logic [INDEX_BITS-1:0] q_index;
  logic [TAG_BITS-1:0]   q_tag;

  dmc_front #(
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .address (address),
    .ctl     (ctl),
    .q_avail (q_avail),
    .q_index (q_index),
    .q_tag   (q_tag)
  );

  dmc_back #(
    .INDEX_BITS (INDEX_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_index    (q_index),
    .q_tag      (q_tag),
    .ctl        (ctl),
    .empty      (empty),
    .pop        (pop),
    .hit        (hit),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

endmodule

// ===== rtl/dmc_checker.sv =====
// Port-level checks for the cache tag lookup core, bound to the top level.
module dmc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic                       hit,
  input logic [dmc_pkg::CNT_W-1:0]  hit_total,
  input logic [dmc_pkg::CNT_W-1:0]  miss_total
);

  // Reset drops any pending result and starts the clearing sweep.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("request taken during tag store clear");

  // Running counts never go backward outside reset.
  a_hit_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hit_total >= $past(hit_total))
    else $error("hit count decreased");

  a_miss_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> miss_total >= $past(miss_total))
    else $error("miss count decreased");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(hit) && $stable(hit_total)
                          && $stable(miss_total)))
    else $error("stalled result changed");

endmodule

bind direct_mapped_cache_hit_miss_core dmc_checker u_dmc_checker (.*);
